/* sv/salted_connection_handshake_top_assert.svh */
// Assertion macros for the salted connection handshake block.
// Included by the modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef SALTED_CONNECTION_HANDSHAKE_TOP_ASSERT_SVH
`define SALTED_CONNECTION_HANDSHAKE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("schc check failed");

// Next-cycle implication, checked outside reset.
`define SCHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("schc check failed");

`endif

/* sv/schc_pkg.sv */
// Shared types and codes for the salted connection handshake block.
// No dependencies; used by schc_cfg, schc_step and the top level.
`timescale 1ns / 1ps

package schc_pkg;

    // phase codes
    localparam logic [2:0] PH_CONNECTING  = 3'd0;
    localparam logic [2:0] PH_CHALLENGING = 3'd1;
    localparam logic [2:0] PH_ALMOST      = 3'd2;
    localparam logic [2:0] PH_CONNECTED   = 3'd3;
    localparam logic [2:0] PH_GIVEN_UP    = 3'd4;

    // request kinds
    localparam logic [1:0] KIND_CONNECT   = 2'd0;
    localparam logic [1:0] KIND_CHALLENGE = 2'd1;
    localparam logic [1:0] KIND_SYNC      = 2'd2;

    // input commands
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_CHALLENGE = 2'd1;
    localparam logic [1:0] CMD_CONNECT   = 2'd2;
    localparam logic [1:0] CMD_SYNC      = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_SALT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GIVE_UP_AFTER  = 2'd2;

    // configuration reset values
    localparam logic [31:0] RST_CLIENT_SALT    = 32'd1;
    localparam logic [31:0] RST_RETRY_INTERVAL = 32'd300;
    localparam logic [31:0] RST_GIVE_UP_AFTER  = 32'd1800;

    typedef struct packed {
        logic [31:0] client_salt;
        logic [31:0] retry_interval;
        logic [31:0] give_up_after;
    } t_cfg;

    typedef struct packed {
        logic [31:0] remote_time;
        logic [31:0] sent_time;
        logic [31:0] peer_salt;
        logic [31:0] echoed_salt;
        logic [31:0] now_tick;
        logic [1:0]  command;
    } t_in;

    typedef struct packed {
        logic        send_valid;
        logic [1:0]  send_kind;
        logic [31:0] send_value;
        logic [2:0]  phase;
        logic        offset_valid;
        logic [31:0] tick_offset;
    } t_out;

endpackage

/* sv/schc_cfg.sv */
// Configuration register file for the salted connection handshake block.
// Depends on schc_pkg for the register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module schc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [schc_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [31:0]                    i_wr_data,
    output schc_pkg::t_cfg                 o_cfg
);

    schc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.client_salt    <= schc_pkg::RST_CLIENT_SALT;
            r_cfg.retry_interval <= schc_pkg::RST_RETRY_INTERVAL;
            r_cfg.give_up_after  <= schc_pkg::RST_GIVE_UP_AFTER;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                schc_pkg::CFG_CLIENT_SALT:    r_cfg.client_salt    <= i_wr_data;
                schc_pkg::CFG_RETRY_INTERVAL: r_cfg.retry_interval <= i_wr_data;
                schc_pkg::CFG_GIVE_UP_AFTER:  r_cfg.give_up_after  <= i_wr_data;
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/schc_step.sv */
// Per-item handshake step: next phase, salts, resend tick and the result item.
// Purely combinational; depends on schc_pkg for codes and structs.
`timescale 1ns / 1ps

module schc_step #(
    parameter int unsigned TICK_WIDTH = 32
) (
    input  schc_pkg::t_cfg         i_cfg,
    input  schc_pkg::t_in          i_item,
    input  logic [2:0]             i_phase,
    input  logic [31:0]            i_combined,
    input  logic [TICK_WIDTH-1:0]  i_next_send,
    output logic [2:0]             o_phase,
    output logic [31:0]            o_combined,
    output logic [TICK_WIDTH-1:0]  o_next_send,
    output schc_pkg::t_out         o_result
);

    localparam int unsigned EW = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;

    logic [TICK_WIDTH-1:0] now_t;
    logic [TICK_WIDTH-1:0] sent_t;
    logic [TICK_WIDTH-1:0] remote_t;
    logic [EW-1:0]         now_e;
    logic [EW:0]           resend_sum;
    logic [TICK_WIDTH-1:0] resend_low;
    logic [TICK_WIDTH-1:0] resend_tick;
    logic [TICK_WIDTH-1:0] rtt;
    logic [TICK_WIDTH-1:0] offset_t;
    logic [EW-1:0]         offset_e;
    logic                  active;
    logic                  deadline;
    logic                  send_now;
    logic                  offset_now;

    assign now_t    = TICK_WIDTH'(i_item.now_tick);
    assign sent_t   = TICK_WIDTH'(i_item.sent_time);
    assign remote_t = TICK_WIDTH'(i_item.remote_time);
    assign now_e    = EW'(now_t);

    assign active   = (i_phase != schc_pkg::PH_CONNECTED) && (i_phase != schc_pkg::PH_GIVEN_UP);
    assign deadline = now_e >= EW'(i_cfg.give_up_after);

    // resend tick saturates when the tick-wide sum wraps below now
    assign resend_sum  = (EW + 1)'(now_t) + (EW + 1)'(i_cfg.retry_interval);
    assign resend_low  = resend_sum[TICK_WIDTH-1:0];
    assign resend_tick = (resend_low < now_t) ? {TICK_WIDTH{1'b1}} : resend_low;

    assign rtt      = now_t - sent_t;
    assign offset_t = remote_t + (rtt >> 1) + TICK_WIDTH'(1);
    assign offset_e = EW'(offset_t);

    always_comb begin
        o_phase     = i_phase;
        o_combined  = i_combined;
        o_next_send = i_next_send;
        send_now    = 1'b0;
        offset_now  = 1'b0;
        if (active) begin
            if (deadline) begin
                o_phase = schc_pkg::PH_GIVEN_UP;
            end else begin
                unique case (i_item.command)
                    schc_pkg::CMD_TICK: begin
                        send_now = now_t >= i_next_send;
                    end
                    schc_pkg::CMD_CHALLENGE: begin
                        if (i_phase != schc_pkg::PH_CHALLENGING &&
                            i_item.echoed_salt == i_cfg.client_salt) begin
                            o_combined = i_cfg.client_salt ^ i_item.peer_salt;
                            o_phase    = schc_pkg::PH_CHALLENGING;
                            send_now   = 1'b1;
                        end
                    end
                    schc_pkg::CMD_CONNECT: begin
                        if (i_phase != schc_pkg::PH_ALMOST &&
                            i_item.echoed_salt == i_combined) begin
                            o_phase  = schc_pkg::PH_ALMOST;
                            send_now = 1'b1;
                        end
                    end
                    schc_pkg::CMD_SYNC: begin
                        if (i_phase == schc_pkg::PH_ALMOST) begin
                            offset_now = 1'b1;
                            o_phase    = schc_pkg::PH_CONNECTED;
                        end
                    end
                    default: ;
                endcase
            end
        end

        o_result              = '0;
        o_result.phase        = o_phase;
        o_result.offset_valid = offset_now;
        o_result.tick_offset  = offset_now ? offset_e[31:0] : 32'd0;
        if (send_now) begin
            o_next_send         = resend_tick;
            o_result.send_valid = 1'b1;
            case (o_phase)
                schc_pkg::PH_CONNECTING: begin
                    o_result.send_kind  = schc_pkg::KIND_CONNECT;
                    o_result.send_value = i_cfg.client_salt;
                end
                schc_pkg::PH_CHALLENGING: begin
                    o_result.send_kind  = schc_pkg::KIND_CHALLENGE;
                    o_result.send_value = o_combined;
                end
                default: begin
                    o_result.send_kind  = schc_pkg::KIND_SYNC;
                    o_result.send_value = now_e[31:0];
                end
            endcase
        end
    end

endmodule

/* sv/salted_connection_handshake_top.sv */
// Top level of the salted connection handshake client.
// Depends on schc_pkg, schc_cfg, schc_step and the assertion macro header.
`timescale 1ns / 1ps
//
// Usage:
//   Slave stream: one request per item. tuser carries the command (tick,
//   challenge, connect, synchronize reply); tdata carries now_tick,
//   echoed_salt, peer_salt, sent_time and remote_time.
//   Master stream: exactly one result per request. tuser carries the flags
//   send_valid, send_kind and offset_valid; tdata carries send_value, the
//   phase after the request and tick_offset.
//   Config channel: write client_salt, retry_interval and give_up_after by
//   index while the block is idle; it is always ready.
// Path: a request passes through the input register, then the result
//   register, before it shows on the master side.
// Throughput: one request per cycle unless stalled; the step logic between the
//   input and result registers updates the handshake state once per request.
// Reset (synchronous, active low): phase returns to connecting, the resend
//   tick and combined salt clear, config returns to its defaults, both
//   streams empty.
// Stall: when the master side holds tready low, the result holds, the input
//   register holds one more request, and tready on the slave side drops
//   only once both are full.

module salted_connection_handshake_top #(
    parameter int unsigned TICK_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [schc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    // slave stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata from bit 0: now_tick[31:0], echoed_salt[63:32], peer_salt[95:64],
    //   sent_time[127:96], remote_time[159:128]
    input  logic [159:0]                   i_s_axis_tdata,
    // tuser from bit 0: command[1:0]
    input  logic [1:0]                     i_s_axis_tuser,
    // master stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata from bit 0: send_value[31:0], phase[34:32], tick_offset[66:35],
    //   zero fill [71:67]
    output logic [71:0]                    o_m_axis_tdata,
    // tuser from bit 0: send_valid[0], send_kind[2:1], offset_valid[3]
    output logic [3:0]                     o_m_axis_tuser
);

    schc_pkg::t_cfg        cfg;
    schc_pkg::t_in         r_in;
    logic                  r_in_valid;
    schc_pkg::t_out        r_out;
    logic                  r_out_valid;
    logic [2:0]            r_phase;
    logic [31:0]           r_combined;
    logic [TICK_WIDTH-1:0] r_next_send;

    logic [2:0]            n_phase;
    logic [31:0]           n_combined;
    logic [TICK_WIDTH-1:0] n_next_send;
    schc_pkg::t_out        n_out;

    logic                  advance;
    logic                  in_take;

    // Config is always ready; the user must write only while idle, the block itself does not enforce it.
    assign o_cfg_ready = 1'b1;

    schc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Advance the held request into the result register whenever that slot
    // is empty or being drained this cycle.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload of the input register needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.command     <= i_s_axis_tuser;
            r_in.now_tick    <= i_s_axis_tdata[31:0];
            r_in.echoed_salt <= i_s_axis_tdata[63:32];
            r_in.peer_salt   <= i_s_axis_tdata[95:64];
            r_in.sent_time   <= i_s_axis_tdata[127:96];
            r_in.remote_time <= i_s_axis_tdata[159:128];
        end
    end

    schc_step #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_step (
        .i_cfg       (cfg),
        .i_item      (r_in),
        .i_phase     (r_phase),
        .i_combined  (r_combined),
        .i_next_send (r_next_send),
        .o_phase     (n_phase),
        .o_combined  (n_combined),
        .o_next_send (n_next_send),
        .o_result    (n_out)
    );

    // Commit the handshake state once per request, together with its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= schc_pkg::PH_CONNECTING;
            r_combined  <= 32'd0;
            r_next_send <= '0;
        end else if (advance) begin
            r_phase     <= n_phase;
            r_combined  <= n_combined;
            r_next_send <= n_next_send;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.tick_offset, r_out.phase, r_out.send_value};
    assign o_m_axis_tuser  = {r_out.offset_valid, r_out.send_kind, r_out.send_valid};

`include "salted_connection_handshake_top_assert.svh"

    // A finished phase never moves again.
    `SCHC_ASSERT_NEXT(a_finished_holds, (r_phase == schc_pkg::PH_CONNECTED || r_phase == schc_pkg::PH_GIVEN_UP), (r_phase == $past(r_phase)))

    // A tick offset is only reported on the request that completes the link.
    `SCHC_ASSERT_NOW(a_offset_connected, (r_out_valid && r_out.offset_valid), (r_out.phase == schc_pkg::PH_CONNECTED && !r_out.send_valid))

    // A challenge response is only sent while challenging.
    `SCHC_ASSERT_NOW(a_kind_phase, (r_out_valid && r_out.send_valid && r_out.send_kind == schc_pkg::KIND_CHALLENGE), (r_out.phase == schc_pkg::PH_CHALLENGING))

    // Back-pressure to the slave side only when both registers are full.
    `SCHC_ASSERT_NOW(a_ready_full, (!o_s_axis_tready), (r_in_valid && r_out_valid))

endmodule

/* sim/salted_connection_handshake_top_test.sv */
// Self-checking testbench for salted_connection_handshake_top.
// Uses schc_pkg and the block alone. A scoreboard class predicts each result and checks it
// against the master stream; the block's own streams are driven directed first, then at random.
`timescale 1ns / 1ps

module salted_connection_handshake_top_test;

    localparam int unsigned CYCLE_LIMIT       = 400000;
    localparam int unsigned ITEMS_PER_SETTING = 280;
    localparam int unsigned TAIL_ITEMS        = 30;
    localparam int unsigned SETTLE_CYCLES     = 4;

    // Client handshake tracker: mirrors the phase, resend tick and combined salt,
    // and keeps the results still owed by the block in arrival order.
    class t_handshake_scoreboard;
        logic [31:0]     client_salt;
        logic [31:0]     retry_interval;
        logic [31:0]     give_up_after;
        logic [2:0]      phase;
        logic [31:0]     next_send_tick;
        logic [31:0]     combined_salt;
        schc_pkg::t_out  owed_results[$];
        int unsigned     failures;
        int unsigned     results_checked;
        int unsigned     offsets_seen;

        function new();
            client_salt     = schc_pkg::RST_CLIENT_SALT;
            retry_interval  = schc_pkg::RST_RETRY_INTERVAL;
            give_up_after   = schc_pkg::RST_GIVE_UP_AFTER;
            phase           = schc_pkg::PH_CONNECTING;
            next_send_tick  = '0;
            combined_salt   = '0;
            failures        = 0;
            results_checked = 0;
            offsets_seen    = 0;
        endfunction

        function void set_register(logic [schc_pkg::CFG_IDX_W-1:0] index,
                                   logic [31:0] value);
            case (index)
                schc_pkg::CFG_CLIENT_SALT:    client_salt = value;
                schc_pkg::CFG_RETRY_INTERVAL: retry_interval = value;
                schc_pkg::CFG_GIVE_UP_AFTER:  give_up_after = value;
                default: ;
            endcase
        endfunction

        // Advance the handshake by one accepted request and queue the result it owes.
        function void absorb_request(schc_pkg::t_in r);
            schc_pkg::t_out e;
            logic           fire;
            logic [31:0]    round_trip;
            logic [32:0]    resend;
            e    = '0;
            fire = 1'b0;
            if (phase != schc_pkg::PH_CONNECTED && phase != schc_pkg::PH_GIVEN_UP) begin
                if (r.now_tick >= give_up_after) begin
                    phase = schc_pkg::PH_GIVEN_UP;
                end else begin
                    case (r.command)
                        schc_pkg::CMD_TICK: begin
                            fire = (r.now_tick >= next_send_tick);
                        end
                        schc_pkg::CMD_CHALLENGE: begin
                            if (phase != schc_pkg::PH_CHALLENGING &&
                                r.echoed_salt == client_salt) begin
                                combined_salt = client_salt ^ r.peer_salt;
                                phase = schc_pkg::PH_CHALLENGING;
                                fire = 1'b1;
                            end
                        end
                        schc_pkg::CMD_CONNECT: begin
                            if (phase != schc_pkg::PH_ALMOST &&
                                r.echoed_salt == combined_salt) begin
                                phase = schc_pkg::PH_ALMOST;
                                fire = 1'b1;
                            end
                        end
                        default: begin
                            if (phase == schc_pkg::PH_ALMOST) begin
                                round_trip = r.now_tick - r.sent_time;
                                e.tick_offset = r.remote_time + (round_trip >> 1) + 32'd1;
                                e.offset_valid = 1'b1;
                                phase = schc_pkg::PH_CONNECTED;
                                offsets_seen++;
                            end
                        end
                    endcase
                end
            end
            if (fire) begin
                e.send_valid = 1'b1;
                case (phase)
                    schc_pkg::PH_CONNECTING: begin
                        e.send_kind  = schc_pkg::KIND_CONNECT;
                        e.send_value = client_salt;
                    end
                    schc_pkg::PH_CHALLENGING: begin
                        e.send_kind  = schc_pkg::KIND_CHALLENGE;
                        e.send_value = combined_salt;
                    end
                    default: begin
                        e.send_kind  = schc_pkg::KIND_SYNC;
                        e.send_value = r.now_tick;
                    end
                endcase
                // resend tick saturates instead of wrapping
                resend = {1'b0, r.now_tick} + {1'b0, retry_interval};
                next_send_tick = resend[32] ? '1 : resend[31:0];
            end
            e.phase = phase;
            owed_results.push_back(e);
        endfunction

        function void check_field(string name, logic [31:0] expected, logic [31:0] actual);
            if (actual !== expected) begin
                $error("%s: expected %0h, got %0h", name, expected, actual);
                failures++;
            end
        endfunction

        function void compare_result(schc_pkg::t_out got);
            schc_pkg::t_out e;
            if (owed_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                failures++;
                return;
            end
            e = owed_results.pop_front();
            check_field("send_valid", 32'(e.send_valid), 32'(got.send_valid));
            check_field("send_kind", 32'(e.send_kind), 32'(got.send_kind));
            check_field("send_value", e.send_value, got.send_value);
            check_field("phase", 32'(e.phase), 32'(got.phase));
            check_field("offset_valid", 32'(e.offset_valid), 32'(got.offset_valid));
            check_field("tick_offset", e.tick_offset, got.tick_offset);
            results_checked++;
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [schc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]                    i_cfg_data = '0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    // remote_time, sent_time, peer_salt, echoed_salt, now_tick (lowest)
    logic [159:0]                   i_s_axis_tdata = '0;
    // command
    logic [1:0]                     i_s_axis_tuser = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    // send_value (lowest), phase, tick_offset, zero fill
    logic [71:0]                    o_m_axis_tdata;
    // send_valid (lowest), send_kind, offset_valid
    logic [3:0]                     o_m_axis_tuser;

    t_handshake_scoreboard sb;
    schc_pkg::t_out        observed;
    int unsigned           requests_sent = 0;
    int unsigned           tx_idle_pct = 15;
    int unsigned           rx_idle_pct = 55;
    int unsigned           cycle_count = 0;
    logic                  end_by_deadline;

    salted_connection_handshake_top #(
        .TICK_WIDTH(32)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tuser(o_m_axis_tuser)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Watchdog: fail the run once the cycle limit is reached, as when the block stops making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check each accepted result, then stall at the current idle rate.
    // Sampling at the edge sees the pre-edge values, so no ordering race with the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                observed              = '0;
                observed.send_value   = o_m_axis_tdata[31:0];
                observed.phase        = o_m_axis_tdata[34:32];
                observed.tick_offset  = o_m_axis_tdata[66:35];
                observed.send_valid   = o_m_axis_tuser[0];
                observed.send_kind    = o_m_axis_tuser[2:1];
                observed.offset_valid = o_m_axis_tuser[3];
                sb.compare_result(observed);
            end
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic schc_pkg::t_in make_request(logic [1:0] command, logic [31:0] now_tick,
                                                   logic [31:0] echoed_salt,
                                                   logic [31:0] peer_salt,
                                                   logic [31:0] sent_time,
                                                   logic [31:0] remote_time);
        schc_pkg::t_in r;
        r.command     = command;
        r.now_tick    = now_tick;
        r.echoed_salt = echoed_salt;
        r.peer_salt   = peer_salt;
        r.sent_time   = sent_time;
        r.remote_time = remote_time;
        return r;
    endfunction

    // Build a request from the tracked state: mostly well-formed challenges and connects
    // that bounce between challenging and almost connected, ticks around the resend point,
    // and some noise. Hold off the synchronize reply in almost connected unless the run
    // may end, since it closes the connection for good.
    function automatic schc_pkg::t_in random_request(logic may_finish);
        schc_pkg::t_in r;
        int unsigned   roll;
        logic [31:0]   latest;
        logic [31:0]   near;
        latest = sb.give_up_after - 32'd1;
        r = make_request(schc_pkg::CMD_TICK, '0, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(1) == 1) begin
            near = sb.next_send_tick - 32'd2 + $urandom_range(4);
            r.now_tick = (near > latest) ? latest : near;
        end else begin
            r.now_tick = $urandom_range(latest);
        end
        if ($urandom_range(9) == 0)
            r.peer_salt = ($urandom_range(1) == 1) ? '1 : '0;
        roll = $urandom_range(99);
        if (roll < 45) begin
            r.command = schc_pkg::CMD_TICK;
        end else if (roll < 62) begin
            r.command     = schc_pkg::CMD_CHALLENGE;
            r.echoed_salt = sb.client_salt;
        end else if (roll < 79) begin
            r.command     = schc_pkg::CMD_CONNECT;
            r.echoed_salt = sb.combined_salt;
        end else if (roll < 87) begin
            r.command = schc_pkg::CMD_CHALLENGE;
        end else if (roll < 93) begin
            r.command = schc_pkg::CMD_CONNECT;
        end else if (may_finish || sb.phase != schc_pkg::PH_ALMOST) begin
            r.command = schc_pkg::CMD_SYNC;
        end
        if (may_finish && $urandom_range(9) == 0)
            r.now_tick = $urandom;
        return r;
    endfunction

    // Present one request, idling first at the current rate, and hold it until accepted.
    task automatic push_request(schc_pkg::t_in r);
        if (requests_sent < 500) begin
            tx_idle_pct = 15;
            rx_idle_pct = 55;
        end else if (requests_sent < 1000) begin
            tx_idle_pct = 55;
            rx_idle_pct = 15;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r.remote_time, r.sent_time, r.peer_salt, r.echoed_salt, r.now_tick};
        i_s_axis_tuser  <= r.command;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.absorb_request(r);
        requests_sent++;
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.owed_results.size() != 0);
    endtask

    task automatic write_register(logic [schc_pkg::CFG_IDX_W-1:0] index, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(index, value);
    endtask

    // Reprogram all three registers while the block is idle.
    task automatic program_registers(logic [31:0] salt, logic [31:0] retry,
                                     logic [31:0] deadline);
        drain_results();
        write_register(schc_pkg::CFG_CLIENT_SALT, salt);
        write_register(schc_pkg::CFG_RETRY_INTERVAL, retry);
        write_register(schc_pkg::CFG_GIVE_UP_AFTER, deadline);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk under the reset settings (salt 1, retry 300, deadline 1800).
        // First tick sends the connect request since the resend tick starts at zero.
        push_request(make_request(schc_pkg::CMD_TICK, 32'd0, '0, '0, '0, '0));
        push_request(make_request(schc_pkg::CMD_TICK, 32'd299, '1, '1, '1, '1));
        push_request(make_request(schc_pkg::CMD_TICK, 32'd300, '0, '0, '0, '0));
        // synchronize reply outside almost connected: ignored
        push_request(make_request(schc_pkg::CMD_SYNC, 32'd5, '0, '0, '1, '1));
        // challenge with the wrong echo: ignored
        push_request(make_request(schc_pkg::CMD_CHALLENGE, 32'd350, '1, '1, '0, '0));
        // connect matching the reset combined salt of zero
        push_request(make_request(schc_pkg::CMD_CONNECT, 32'd400, '0, '0, '0, '0));
        // repeated connect while almost connected: ignored
        push_request(make_request(schc_pkg::CMD_CONNECT, 32'd401, '0, '0, '0, '0));
        // periodic synchronize resend
        push_request(make_request(schc_pkg::CMD_TICK, 32'd700, '0, '0, '0, '0));
        // accepted challenge from almost connected, server salt all ones
        push_request(make_request(schc_pkg::CMD_CHALLENGE, 32'd710, 32'd1, '1, '0, '0));
        // repeated challenge while challenging: ignored
        push_request(make_request(schc_pkg::CMD_CHALLENGE, 32'd711, 32'd1, '0, '0, '0));
        push_request(make_request(schc_pkg::CMD_CONNECT, 32'd712, '0, '1, '1, '1));
        push_request(make_request(schc_pkg::CMD_TICK, 32'd1009, '0, '0, '0, '0));
        push_request(make_request(schc_pkg::CMD_TICK, 32'd1010, '0, '0, '0, '0));
        push_request(make_request(schc_pkg::CMD_CONNECT, 32'd1100, 32'hFFFF_FFFE,
                                  '0, '0, '0));
        push_request(make_request(schc_pkg::CMD_CHALLENGE, 32'd1200, 32'd1, '0, '0, '0));
        // last tick before the deadline
        push_request(make_request(schc_pkg::CMD_TICK, 32'd1799, '1, '1, '1, '1));
        push_request(make_request(schc_pkg::CMD_TICK, 32'd0, '0, '0, '0, '0));

        for (int n = 0; n < ITEMS_PER_SETTING; n++)
            push_request(random_request(1'b0));

        // extremes: all-ones salt, resend on every tick, latest deadline
        program_registers('1, 32'd1, '1);
        for (int n = 0; n < ITEMS_PER_SETTING; n++)
            push_request(random_request(1'b0));

        // smallest salt, resend tick always saturates
        program_registers(32'd1, '1, '1);
        for (int n = 0; n < ITEMS_PER_SETTING; n++)
            push_request(random_request(1'b0));

        program_registers($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(1000, 1),
                          $urandom_range(32'hFFFF_FFFF, 32'h1000_0000));
        for (int n = 0; n < ITEMS_PER_SETTING; n++)
            push_request(random_request(1'b0));

        // earliest deadline: only tick zero stays active
        program_registers($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(32'hFFFF_FFFF, 1),
                          32'd1);
        for (int n = 0; n < ITEMS_PER_SETTING; n++)
            push_request(random_request(1'b0));

        // Close the attempt one of two ways: a synchronize reply or the deadline.
        end_by_deadline = 1'($urandom_range(1));
        if (!end_by_deadline) begin
            program_registers(sb.client_salt, sb.retry_interval, '1);
            if (sb.phase != schc_pkg::PH_ALMOST)
                push_request(make_request(schc_pkg::CMD_CONNECT,
                                          $urandom_range(32'hFFFF_FFFE),
                                          sb.combined_salt, $urandom, $urandom, $urandom));
            push_request(make_request(schc_pkg::CMD_SYNC, $urandom_range(32'hFFFF_FFFE),
                                      $urandom, $urandom, $urandom, $urandom));
        end else begin
            program_registers(sb.client_salt, sb.retry_interval,
                              $urandom_range(32'hFFFF_FFFF, 1));
            push_request(make_request(2'($urandom_range(schc_pkg::CMD_SYNC)),
                                      sb.give_up_after, $urandom,
                                      $urandom, $urandom, $urandom));
        end
        // finished phase holds no matter what arrives
        for (int n = 0; n < TAIL_ITEMS; n++)
            push_request(random_request(1'b1));

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("tb: %0d requests sent, %0d results checked across five register settings",
                 requests_sent, sb.results_checked);
        $display("tb: attempt closed by %s, final phase %0d, %0d tick offsets produced",
                 end_by_deadline ? "deadline" : "synchronize reply", sb.phase,
                 sb.offsets_seen);
        if (sb.failures == 0 && sb.owed_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
